### rtl/crwq_pkg.sv
// ----------------------------------------------------------------------------
// crwq_pkg
// Shared types, codes and a word-building helper of the channel report word
// queue.
// ----------------------------------------------------------------------------
package crwq_pkg;

  // Port widths
  localparam int unsigned FuncW      = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 5;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 40;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 6;
  localparam int unsigned ErcW       = 6;
  localparam int unsigned PathIdW    = 8;
  localparam int unsigned SubchW     = 16;
  localparam int unsigned SsidW      = 8;

  // Report word layout
  localparam logic [WordW-1:0] WordSol   = 32'h4000_0000;
  localparam logic [WordW-1:0] WordOflow = 32'h2000_0000;
  localparam logic [WordW-1:0] WordChain = 32'h1000_0000;
  localparam logic [WordW-1:0] WordAncil = 32'h0080_0000;
  localparam logic [3:0]       SrcSubch  = 4'd3;
  localparam logic [3:0]       SrcPath   = 4'd4;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgShutdown   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMultiSs    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgErcAlert   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgErcFound   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgErcNoFound = 3'd4;

  // Register reset values
  localparam logic [ErcW-1:0] ErcAlertRst   = 6'd4;
  localparam logic [ErcW-1:0] ErcFoundRst   = 6'd2;
  localparam logic [ErcW-1:0] ErcNoFoundRst = 6'd6;

  typedef enum logic [FuncW-1:0] {
    FUNC_PATH_RESET = 2'd0,
    FUNC_ATTACH     = 2'd1,
    FUNC_READ       = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_DROP    = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WR2,
    S_OFLW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic            shutting_down;
    logic            multiple_subsystems;
    logic [ErcW-1:0] erc_alert;
    logic [ErcW-1:0] erc_path_found;
    logic [ErcW-1:0] erc_path_not_found;
  } cfg_t;

  // Assemble a report word from source code, recovery code and source id
  function automatic logic [WordW-1:0] make_word(input logic [3:0]        src,
                                                 input logic [ErcW-1:0]   erc,
                                                 input logic [SubchW-1:0] id);
    logic [WordW-1:0] w;
    w = WordAncil;
    w[27:24] = src;
    w[21:16] = erc;
    w[15:0]  = id;
    return w;
  endfunction

endpackage

### rtl/crwq_cfg.sv
// ----------------------------------------------------------------------------
// crwq_cfg
// Configuration registers: shutdown, chaining and the three recovery codes.
// ----------------------------------------------------------------------------
module crwq_cfg
  import crwq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index and update one field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShutdown:   cfg_d.shutting_down       = cfg_data_i[0];
        CfgMultiSs:    cfg_d.multiple_subsystems = cfg_data_i[0];
        CfgErcAlert:   cfg_d.erc_alert           = cfg_data_i;
        CfgErcFound:   cfg_d.erc_path_found      = cfg_data_i;
        CfgErcNoFound: cfg_d.erc_path_not_found  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shutting_down       <= 1'b0;
      cfg_q.multiple_subsystems <= 1'b0;
      cfg_q.erc_alert           <= ErcAlertRst;
      cfg_q.erc_path_found      <= ErcFoundRst;
      cfg_q.erc_path_not_found  <= ErcNoFoundRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/crwq_mem.sv
// ----------------------------------------------------------------------------
// crwq_mem
// Report word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crwq_mem
  import crwq_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] store_q [Depth];
  logic [WordW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/crwq_ctrl.sv
// ----------------------------------------------------------------------------
// crwq_ctrl
// Sequencer of the queue: decodes a word, builds and appends report words,
// marks overflow by read-modify-write, drains reads and holds the result.
// ----------------------------------------------------------------------------
module crwq_ctrl
  import crwq_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned CntW  = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  // input side
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FuncW-1:0]    func_i,
  input  logic [PathIdW-1:0]  path_id_i,
  input  logic                solicited_i,
  input  logic                found_i,
  input  logic [SubchW-1:0]   subchannel_i,
  input  logic [SsidW-1:0]    ssid_i,
  // result side
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WordW-1:0]    read_word_o,
  output logic [StatusW-1:0]  status_o,
  output logic [CountW-1:0]   stored_count_o,
  // store
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [WordW-1:0]    mem_wdata_o,
  output logic                mem_re_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [WordW-1:0]    mem_rdata_i
);

  localparam logic [CntW-1:0] DepthC   = CntW'(Depth);
  localparam logic [CntW-1:0] DepthM1C = CntW'(Depth - 1);

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     rp_q, rp_d;
  logic [SsidW-1:0]    ssid_q, ssid_d;
  status_e             res_status_q, res_status_d;
  logic                res_mem_q, res_mem_d;
  logic                out_valid_q, out_valid_d;
  logic [WordW-1:0]    out_word_q, out_word_d;
  status_e             out_status_q, out_status_d;
  logic [CountW-1:0]   out_count_q, out_count_d;

  logic                accept;
  logic                is_path, is_attach, is_read;
  logic                chained;
  logic                room;
  logic                cnt_zero;
  logic                rd_hit;
  logic                out_free;
  logic [CntW-1:0]     cnt_m1;
  logic [WordW-1:0]    path_word;
  logic [WordW-1:0]    attach_word;
  logic [WordW-1:0]    second_word;
  logic [ErcW-1:0]     path_erc;

  // Decode the incoming word
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_path    = (func_i == FUNC_PATH_RESET) && !cfg_i.shutting_down;
  assign is_attach  = (func_i == FUNC_ATTACH) && !cfg_i.shutting_down;
  assign is_read    = (func_i == FUNC_READ);
  assign chained    = cfg_i.multiple_subsystems;
  assign cnt_zero   = (cnt_q == '0);
  assign cnt_m1     = cnt_q - CntW'(1);
  assign rd_hit     = (rp_q < cnt_q);
  assign out_free   = !out_valid_q || out_ready_i;

  // Room for one word, or for two when the report is chained
  always_comb begin
    if (is_attach && chained) begin
      room = (cnt_q < DepthM1C);
    end else begin
      room = (cnt_q < DepthC);
    end
  end

  // Build report words
  assign path_erc    = found_i ? cfg_i.erc_path_found : cfg_i.erc_path_not_found;
  assign path_word   = (solicited_i ? WordSol : '0) |
                       make_word(SrcPath, path_erc, {8'h00, path_id_i});
  assign attach_word = (chained ? WordChain : '0) |
                       make_word(SrcSubch, cfg_i.erc_alert, subchannel_i);
  assign second_word = make_word(SrcSubch, cfg_i.erc_alert, {ssid_q, 8'h00});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((is_path || is_attach) && room && is_attach && chained) begin
            state_d = S_WR2;
          end else if ((is_path || is_attach) && !room && !cnt_zero) begin
            state_d = S_OFLW;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WR2:   state_d = S_DONE;
      S_OFLW:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and store accesses
  always_comb begin
    cnt_d        = cnt_q;
    rp_d         = rp_q;
    ssid_d       = ssid_q;
    res_status_d = res_status_q;
    res_mem_d    = res_mem_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_word_d   = out_word_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cnt_q[AddrW-1:0];
    mem_wdata_o  = path_word;
    mem_re_o     = 1'b0;
    mem_raddr_o  = rp_q[AddrW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ssid_d       = ssid_i;
          res_mem_d    = 1'b0;
          res_status_d = STAT_IGNORED;
          if (is_path || is_attach) begin
            if (room) begin
              // append the first word
              mem_we_o     = 1'b1;
              mem_wdata_o  = is_attach ? attach_word : path_word;
              cnt_d        = cnt_q + CntW'(1);
              res_status_d = STAT_OK;
            end else begin
              // drop, fetch the last stored word for marking
              mem_re_o     = !cnt_zero;
              mem_raddr_o  = cnt_m1[AddrW-1:0];
              res_status_d = STAT_DROP;
            end
          end else if (is_read) begin
            if (cnt_zero) begin
              res_status_d = STAT_EMPTY;
            end else if (rd_hit) begin
              mem_re_o     = 1'b1;
              rp_d         = rp_q + CntW'(1);
              res_mem_d    = 1'b1;
              res_status_d = STAT_OK;
            end else begin
              // read past the end empties the queue
              cnt_d        = '0;
              rp_d         = '0;
              res_status_d = STAT_EMPTY;
            end
          end
        end
      end
      S_WR2: begin
        // append the chained word
        mem_we_o    = 1'b1;
        mem_wdata_o = second_word;
        cnt_d       = cnt_q + CntW'(1);
      end
      S_OFLW: begin
        // set overflow in the last stored word
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_m1[AddrW-1:0];
        mem_wdata_o = mem_rdata_i | WordOflow;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_word_d   = res_mem_q ? mem_rdata_i : '0;
          out_status_d = res_status_q;
          out_count_d  = CountW'(cnt_q);
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ssid_q       <= ssid_d;
    res_status_q <= res_status_d;
    res_mem_q    <= res_mem_d;
    out_word_q   <= out_word_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_word_o    = out_word_q;
  assign status_o       = out_status_q;
  assign stored_count_o = out_count_q;

endmodule

### rtl/channel_report_word_queue.sv
// ----------------------------------------------------------------------------
// channel_report_word_queue
// Builds channel report words from path reset and attach/detach events,
// queues them in a word store and returns them one per read.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: func; tdata: event fields or read request
//  m_axis    out        tuser: status; tdata: read word, stored count
//  cfg       in         register index and write data, no read-back
//
//  A path reset, a single attach/detach or a read passes from acceptance
//  through the done state into the result register once m_axis is free;
//  a chained report or an overflow marking first passes the second-write
//  or overflow-marking state, set by the single write port and the
//  registered read data of the store. One word is in work at a time; the
//  next is taken while the previous result waits on m_axis. Reset empties
//  the queue by its counters at once; the store itself is not cleared.
// ----------------------------------------------------------------------------
module channel_report_word_queue
  import crwq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // event and read words
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] path_id, [8] solicited, [9] subchannel_found,
  // [25:10] subchannel, [33:26] subsystem_id, [39:34] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] func
  input  logic [FuncW-1:0]    s_axis_tuser,
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] read_word, [36:32] stored_count, [39:37] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] status
  output logic [StatusW-1:0]  m_axis_tuser,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  cfg_t               cfg;
  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  logic [WordW-1:0]   mem_wdata;
  logic               mem_re;
  logic [AddrW-1:0]   mem_raddr;
  logic [WordW-1:0]   mem_rdata;
  logic [WordW-1:0]   read_word;
  logic [CountW-1:0]  stored_count;

  crwq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  crwq_mem #(
    .Depth (QUEUE_DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  crwq_ctrl #(
    .Depth (QUEUE_DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .func_i         (s_axis_tuser),
    .path_id_i      (s_axis_tdata[7:0]),
    .solicited_i    (s_axis_tdata[8]),
    .found_i        (s_axis_tdata[9]),
    .subchannel_i   (s_axis_tdata[25:10]),
    .ssid_i         (s_axis_tdata[33:26]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .read_word_o    (read_word),
    .status_o       (m_axis_tuser),
    .stored_count_o (stored_count),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Pack the result word
  assign m_axis_tdata = {3'b000, stored_count, read_word};

endmodule

### rtl/crwq_checker.sv
// ----------------------------------------------------------------------------
// crwq_checker
// Port-level checks of the channel report word queue, bound to the top level.
// ----------------------------------------------------------------------------
module crwq_checker
  import crwq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [StatusW-1:0]  m_axis_tuser
);

  // Count never exceeds the queue depth where it fits the field
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (QUEUE_DEPTH < 32) |-> m_axis_tdata[36:32] <= CountW'(QUEUE_DEPTH))
    else $error("stored count beyond queue depth");

  // An empty read leaves an empty queue and returns zero
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_EMPTY) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[36:32] == '0))
    else $error("empty read with data or count");

  // Dropped and ignored words return no data
  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == STAT_DROP) || (m_axis_tuser == STAT_IGNORED)) |->
      m_axis_tdata[31:0] == '0)
    else $error("read word on a non-read result");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One word in work at a time: an accepted word closes the input
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

endmodule

bind channel_report_word_queue crwq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_crwq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
